[src/sfwp_pkg.sv]
// Package with section codes, status codes and a helper function of the frame word parser.
package sfwp_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned CountW = 31;
	localparam int unsigned SecW   = 4;
	localparam int unsigned StatW  = 3;

	localparam logic [WordW-1:0]  MagicV1    = 32'h464D_4953;
	localparam logic [WordW-1:0]  MagicV2    = 32'h464D_4932;
	localparam logic [CountW-1:0] LimitReset = 31'd2000000;

	typedef enum logic [SecW-1:0] {
		SEC_MAGIC = 4'd0,
		SEC_STEP  = 4'd1,
		SEC_TIME  = 4'd2,
		SEC_FLUID = 4'd3,
		SEC_TOTAL = 4'd4,
		SEC_X     = 4'd5,
		SEC_Y     = 4'd6,
		SEC_Z     = 4'd7,
		SEC_DENS  = 4'd8,
		SEC_POS   = 4'd9,
		SEC_QUAT  = 4'd10,
		SEC_HALF  = 4'd11,
		SEC_NONE  = 4'd12
	} sec_t;

	typedef enum logic [StatW-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_MAGIC = 3'd1,
		ST_BAD_COUNT = 3'd2,
		ST_TRUNC     = 3'd3,
		ST_CLEAN_END = 3'd4,
		ST_HALTED    = 3'd5
	} status_t;

	// Returns the next array section after cur that holds at least one word,
	// or the magic section when the frame is complete.
	function automatic sec_t next_sec(sec_t cur, logic tot_nz, logic flu_nz, logic die);
		logic [SEC_HALF:0] nonempty;
		sec_t              res;
		nonempty           = '0;
		nonempty[SEC_X]    = tot_nz;
		nonempty[SEC_Y]    = tot_nz;
		nonempty[SEC_Z]    = tot_nz;
		nonempty[SEC_DENS] = flu_nz;
		nonempty[SEC_POS]  = die;
		nonempty[SEC_QUAT] = die;
		nonempty[SEC_HALF] = die;
		res = SEC_MAGIC;
		for (int i = SEC_HALF; i >= SEC_X; i--) begin
			if ((SecW'(i) > cur) && nonempty[i]) begin
				res = sec_t'(SecW'(i));
			end
		end
		return res;
	endfunction

endpackage

[src/sim_frame_word_parser_top.sv]
// Top level of the simulation frame word parser.
// Results are registered: each appears on the output register in the cycle after its input transaction.
// Throughput: one word per cycle; the input is taken whenever the output register
// is empty or being emptied in the same cycle.
// Reset clears the parse state, the sticky halt and the output valid, and loads the
// particle limit with its default of 2000000.
module sim_frame_word_parser_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [sfwp_pkg::WordW-1:0]         data_word,
	input  logic                               end_of_stream,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [sfwp_pkg::SecW-1:0]          section,
	output logic [sfwp_pkg::CountW-1:0]        element_index,
	output logic [sfwp_pkg::WordW-1:0]         word_out,
	output logic                               frame_has_die,
	output logic                               frame_end,
	output logic [sfwp_pkg::StatW-1:0]         status,
	input  logic                               cfg_wr_en,
	input  logic [sfwp_pkg::CountW-1:0]        cfg_wr_data
);

	localparam int unsigned CW = sfwp_pkg::CountW;
	localparam int unsigned WW = sfwp_pkg::WordW;

	sfwp_pkg::sec_t      phase_q;
	logic [CW-1:0]       elem_cnt_q;
	logic [CW-1:0]       fluid_cnt_q;
	logic [CW-1:0]       total_cnt_q;
	logic [WW-1:0]       fluid_raw_q;
	logic                die_q;
	logic                halted_q;
	logic [CW-1:0]       max_cnt_q;

	logic                out_valid_q;
	sfwp_pkg::sec_t      sec_q;
	logic [CW-1:0]       idx_q;
	logic [WW-1:0]       wout_q;
	logic                has_die_q;
	logic                fend_q;
	sfwp_pkg::status_t   status_q;

	sfwp_pkg::sec_t      phase_d;
	logic [CW-1:0]       elem_cnt_d;
	logic [CW-1:0]       fluid_cnt_d;
	logic [CW-1:0]       total_cnt_d;
	logic [WW-1:0]       fluid_raw_d;
	logic                die_d;
	logic                halted_d;

	sfwp_pkg::sec_t      sec_d;
	logic [CW-1:0]       idx_d;
	logic [WW-1:0]       wout_d;
	logic                has_die_d;
	logic                fend_d;
	sfwp_pkg::status_t   status_d;

	logic                accept;
	logic                counts_ok;
	logic [CW-1:0]       cnt_inc;
	logic [CW-1:0]       sec_len;
	sfwp_pkg::sec_t      nxt;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign counts_ok = !fluid_raw_q[WW-1] && !data_word[WW-1] &&
		(fluid_raw_q <= data_word) && (data_word <= {1'b0, max_cnt_q});
	assign cnt_inc   = elem_cnt_q + CW'(1);

	always_comb begin
		case (phase_q)
			sfwp_pkg::SEC_X, sfwp_pkg::SEC_Y, sfwp_pkg::SEC_Z: sec_len = total_cnt_q;
			sfwp_pkg::SEC_DENS: sec_len = fluid_cnt_q;
			sfwp_pkg::SEC_POS, sfwp_pkg::SEC_HALF: sec_len = die_q ? CW'(3) : '0;
			sfwp_pkg::SEC_QUAT: sec_len = die_q ? CW'(4) : '0;
			default: sec_len = '0;
		endcase
	end

	always_comb begin
		phase_d     = phase_q;
		elem_cnt_d  = elem_cnt_q;
		fluid_cnt_d = fluid_cnt_q;
		total_cnt_d = total_cnt_q;
		fluid_raw_d = fluid_raw_q;
		die_d       = die_q;
		halted_d    = halted_q;
		sec_d       = sfwp_pkg::SEC_NONE;
		idx_d       = '0;
		wout_d      = '0;
		has_die_d   = 1'b0;
		fend_d      = 1'b0;
		status_d    = sfwp_pkg::ST_OK;
		nxt         = sfwp_pkg::SEC_MAGIC;

		if (halted_q) begin
			status_d = sfwp_pkg::ST_HALTED;
		end else if (end_of_stream) begin
			if (phase_q == sfwp_pkg::SEC_MAGIC) begin
				status_d = sfwp_pkg::ST_CLEAN_END;
			end else begin
				status_d  = sfwp_pkg::ST_TRUNC;
				has_die_d = die_q;
			end
			halted_d = 1'b1;
		end else begin
			sec_d  = phase_q;
			wout_d = data_word;
			case (phase_q)
				sfwp_pkg::SEC_MAGIC: begin
					if (data_word == sfwp_pkg::MagicV1 || data_word == sfwp_pkg::MagicV2) begin
						die_d   = (data_word == sfwp_pkg::MagicV2);
						phase_d = sfwp_pkg::SEC_STEP;
					end else begin
						die_d    = 1'b0;
						status_d = sfwp_pkg::ST_BAD_MAGIC;
						halted_d = 1'b1;
					end
				end
				sfwp_pkg::SEC_STEP: phase_d = sfwp_pkg::SEC_TIME;
				sfwp_pkg::SEC_TIME: phase_d = sfwp_pkg::SEC_FLUID;
				sfwp_pkg::SEC_FLUID: begin
					fluid_raw_d = data_word;
					phase_d     = sfwp_pkg::SEC_TOTAL;
				end
				sfwp_pkg::SEC_TOTAL: begin
					if (!counts_ok) begin
						status_d = sfwp_pkg::ST_BAD_COUNT;
						halted_d = 1'b1;
					end else begin
						fluid_cnt_d = fluid_raw_q[CW-1:0];
						total_cnt_d = data_word[CW-1:0];
						elem_cnt_d  = '0;
						nxt = sfwp_pkg::next_sec(sfwp_pkg::SEC_TOTAL,
							data_word[CW-1:0] != '0, fluid_raw_q[CW-1:0] != '0, die_q);
						phase_d = nxt;
						fend_d  = (nxt == sfwp_pkg::SEC_MAGIC);
					end
				end
				sfwp_pkg::SEC_X, sfwp_pkg::SEC_Y, sfwp_pkg::SEC_Z, sfwp_pkg::SEC_DENS,
				sfwp_pkg::SEC_POS, sfwp_pkg::SEC_QUAT, sfwp_pkg::SEC_HALF: begin
					idx_d      = elem_cnt_q;
					elem_cnt_d = cnt_inc;
					if (cnt_inc >= sec_len) begin
						elem_cnt_d = '0;
						nxt = sfwp_pkg::next_sec(phase_q, total_cnt_q != '0,
							fluid_cnt_q != '0, die_q);
						phase_d = nxt;
						fend_d  = (nxt == sfwp_pkg::SEC_MAGIC);
					end
				end
				default: begin
					phase_d = sfwp_pkg::SEC_MAGIC;
					sec_d   = sfwp_pkg::SEC_NONE;
					wout_d  = '0;
				end
			endcase
			has_die_d = die_q && !(phase_q == sfwp_pkg::SEC_MAGIC && status_d != sfwp_pkg::ST_OK);
			if (phase_q == sfwp_pkg::SEC_MAGIC) begin
				has_die_d = die_d;
			end
			if (fend_d) begin
				die_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sfwp_pkg::SEC_MAGIC;
			elem_cnt_q  <= '0;
			fluid_cnt_q <= '0;
			total_cnt_q <= '0;
			fluid_raw_q <= '0;
			die_q       <= 1'b0;
			halted_q    <= 1'b0;
			max_cnt_q   <= sfwp_pkg::LimitReset;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_cnt_q <= cfg_wr_data;
			end
			if (accept) begin
				phase_q     <= phase_d;
				elem_cnt_q  <= elem_cnt_d;
				fluid_cnt_q <= fluid_cnt_d;
				total_cnt_q <= total_cnt_d;
				fluid_raw_q <= fluid_raw_d;
				die_q       <= die_d;
				halted_q    <= halted_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sec_q     <= sec_d;
			idx_q     <= idx_d;
			wout_q    <= wout_d;
			has_die_q <= has_die_d;
			fend_q    <= fend_d;
			status_q  <= status_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign section       = sec_q;
	assign element_index = idx_q;
	assign word_out      = wout_q;
	assign frame_has_die = has_die_q;
	assign frame_end     = fend_q;
	assign status        = status_q;

endmodule

[tb/sv/sim_frame_word_parser_top_test.sv]
// Self-checking testbench that streams simulation frames through the frame word parser.
`timescale 1ns / 100ps

module sim_frame_word_parser_top_test;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned WW = sfwp_pkg::WordW;
	localparam int unsigned CW = sfwp_pkg::CountW;
	localparam int unsigned SW = sfwp_pkg::SecW;
	localparam int unsigned TW = sfwp_pkg::StatW;

	typedef struct {
		sfwp_pkg::sec_t     sec;
		logic [CW-1:0]      idx;
		logic [WW-1:0]      word;
		logic               die;
		logic               fend;
		sfwp_pkg::status_t  st;
	} word_tag_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [WW-1:0]      data_word = '0;
	logic               end_of_stream = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [SW-1:0]      section;
	logic [CW-1:0]      element_index;
	logic [WW-1:0]      word_out;
	logic               frame_has_die;
	logic               frame_end;
	logic [TW-1:0]      status;
	logic               cfg_wr_en = 1'b0;
	logic [CW-1:0]      cfg_wr_data = '0;

	// Parser state as predicted by the testbench.
	logic [CW-1:0]      pr_limit = sfwp_pkg::LimitReset;
	sfwp_pkg::sec_t     pr_phase = sfwp_pkg::SEC_MAGIC;
	logic [CW-1:0]      pr_index = '0;
	logic [CW-1:0]      pr_fluid = '0;
	logic [CW-1:0]      pr_total = '0;
	logic [WW-1:0]      pr_fluid_raw = '0;
	logic               pr_die = 1'b0;
	logic               pr_halted = 1'b0;

	word_tag_t          expected_tags[$];
	int unsigned        words_sent = 0;
	int unsigned        mismatch_count = 0;
	int unsigned        cycle_count = 0;
	int unsigned        src_gap_pct = 0;
	int unsigned        sink_stall_pct = 0;

	sim_frame_word_parser_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_word     (data_word),
		.end_of_stream (end_of_stream),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.section       (section),
		.element_index (element_index),
		.word_out      (word_out),
		.frame_has_die (frame_has_die),
		.frame_end     (frame_end),
		.status        (status),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("sim_frame_word_parser_top: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	function automatic logic [CW-1:0] span_of(sfwp_pkg::sec_t s);
		case (s)
			sfwp_pkg::SEC_X, sfwp_pkg::SEC_Y, sfwp_pkg::SEC_Z: return pr_total;
			sfwp_pkg::SEC_DENS:                   return pr_fluid;
			sfwp_pkg::SEC_POS, sfwp_pkg::SEC_HALF: return pr_die ? 31'd3 : 31'd0;
			sfwp_pkg::SEC_QUAT:                   return pr_die ? 31'd4 : 31'd0;
			default:                              return '0;
		endcase
	endfunction

	// First array section after s that holds words, or the magic word when the frame is done.
	function automatic sfwp_pkg::sec_t following(sfwp_pkg::sec_t s);
		sfwp_pkg::sec_t n;
		n = sfwp_pkg::SEC_MAGIC;
		for (int k = sfwp_pkg::SEC_HALF; k > s; k--) begin
			if (k >= sfwp_pkg::SEC_X && span_of(sfwp_pkg::sec_t'(k[SW-1:0])) != '0) begin
				n = sfwp_pkg::sec_t'(k[SW-1:0]);
			end
		end
		return n;
	endfunction

	function automatic word_tag_t tag_word(logic [WW-1:0] w, logic eos);
		word_tag_t r;
		r.sec  = sfwp_pkg::SEC_NONE;
		r.idx  = '0;
		r.word = '0;
		r.die  = 1'b0;
		r.fend = 1'b0;
		r.st   = sfwp_pkg::ST_OK;
		if (pr_halted) begin
			r.st = sfwp_pkg::ST_HALTED;
		end else if (eos) begin
			if (pr_phase == sfwp_pkg::SEC_MAGIC) begin
				r.st = sfwp_pkg::ST_CLEAN_END;
			end else begin
				r.st  = sfwp_pkg::ST_TRUNC;
				r.die = pr_die;
			end
			pr_halted = 1'b1;
		end else begin
			r.sec  = pr_phase;
			r.word = w;
			case (pr_phase)
				sfwp_pkg::SEC_MAGIC: begin
					if (w == sfwp_pkg::MagicV1 || w == sfwp_pkg::MagicV2) begin
						pr_die   = (w == sfwp_pkg::MagicV2);
						pr_phase = sfwp_pkg::SEC_STEP;
					end else begin
						pr_die    = 1'b0;
						r.st      = sfwp_pkg::ST_BAD_MAGIC;
						pr_halted = 1'b1;
					end
				end
				sfwp_pkg::SEC_STEP:  pr_phase = sfwp_pkg::SEC_TIME;
				sfwp_pkg::SEC_TIME:  pr_phase = sfwp_pkg::SEC_FLUID;
				sfwp_pkg::SEC_FLUID: begin
					pr_fluid_raw = w;
					pr_phase     = sfwp_pkg::SEC_TOTAL;
				end
				sfwp_pkg::SEC_TOTAL: begin
					if (pr_fluid_raw[WW-1] || w[WW-1] || pr_fluid_raw > w ||
							w > {1'b0, pr_limit}) begin
						r.st      = sfwp_pkg::ST_BAD_COUNT;
						pr_halted = 1'b1;
					end else begin
						pr_fluid = pr_fluid_raw[CW-1:0];
						pr_total = w[CW-1:0];
						pr_index = '0;
						pr_phase = following(sfwp_pkg::SEC_TOTAL);
						r.fend   = (pr_phase == sfwp_pkg::SEC_MAGIC);
					end
				end
				default: begin
					r.idx    = pr_index;
					pr_index = pr_index + 1'b1;
					if (pr_index >= span_of(pr_phase)) begin
						pr_index = '0;
						pr_phase = following(pr_phase);
						r.fend   = (pr_phase == sfwp_pkg::SEC_MAGIC);
					end
				end
			endcase
			r.die = pr_die;
			if (r.fend) begin
				pr_die = 1'b0;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [WW-1:0] got, logic [WW-1:0] want);
		mismatch_count++;
		if (mismatch_count <= 40) begin
			$display("%0t: %s is 0x%0h, predicted 0x%0h", $time, what, got, want);
		end
	endtask

	always @(posedge clk) begin
		word_tag_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_tags.size() == 0) begin
				report_mismatch("result with no transaction pending, word_out", word_out, '0);
			end else begin
				want = expected_tags.pop_front();
				if (section != want.sec)
					report_mismatch("section", WW'(section), WW'(want.sec));
				if (element_index != want.idx)
					report_mismatch("element_index", WW'(element_index), WW'(want.idx));
				if (word_out != want.word)
					report_mismatch("word_out", word_out, want.word);
				if (frame_has_die != want.die)
					report_mismatch("frame_has_die", WW'(frame_has_die), WW'(want.die));
				if (frame_end != want.fend)
					report_mismatch("frame_end", WW'(frame_end), WW'(want.fend));
				if (status != want.st)
					report_mismatch("status", WW'(status), WW'(want.st));
			end
		end
	end

	function automatic logic [WW-1:0] rand_word();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(logic [WW-1:0] w, logic eos);
		while ($urandom_range(99) < src_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		data_word     <= w;
		end_of_stream <= eos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_tags.push_back(tag_word(w, eos));
		words_sent++;
	endtask

	// Sends at most max_words words of a frame built on the given header counts.
	task automatic send_frame(logic v2, logic [WW-1:0] fluid_w, logic [WW-1:0] total_w,
			int unsigned max_words);
		longint unsigned body;
		int unsigned     n;
		logic [WW-1:0]   w;
		body = 64'(total_w) * 3 + 64'(fluid_w) + (v2 ? 10 : 0);
		for (n = 0; n < max_words && n < 5 + body; n++) begin
			case (n)
				0:       w = v2 ? sfwp_pkg::MagicV2 : sfwp_pkg::MagicV1;
				3:       w = fluid_w;
				4:       w = total_w;
				default: w = rand_word();
			endcase
			send_item(w, 1'b0);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_tags.size() != 0) @(posedge clk);
	endtask

	task automatic set_particle_limit(logic [CW-1:0] value);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		pr_limit     = value;
	endtask

	task automatic test_empty_frame();
		send_frame(1'b0, 32'd0, 32'd0, '1);
	endtask

	task automatic test_word_extremes();
		send_item(sfwp_pkg::MagicV1, 1'b0);
		send_item(32'h0000_0000, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'd1, 1'b0);
		send_item(32'd1, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'h0000_0000, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'h0000_0000, 1'b0);
	endtask

	task automatic test_zero_limit();
		set_particle_limit('0);
		send_frame(1'b1, 32'd0, 32'd0, '1);
	endtask

	task automatic test_random_frames(int unsigned gap_pct, int unsigned stall_pct,
			logic [CW-1:0] limit, int unsigned budget);
		int unsigned stop_at;
		int unsigned cap;
		int unsigned total;
		int unsigned fluid;
		set_particle_limit(limit);
		src_gap_pct    = gap_pct;
		sink_stall_pct = stall_pct;
		stop_at = words_sent + budget;
		while (words_sent < stop_at) begin
			cap = (pr_limit < 8) ? pr_limit : 8;
			if ($urandom_range(15) == 0) begin
				cap = (pr_limit < 150) ? pr_limit : 150;
			end
			total = ($urandom_range(3) == 0) ? cap : $urandom_range(cap);
			case ($urandom_range(3))
				0:       fluid = 0;
				1:       fluid = total;
				default: fluid = $urandom_range(total);
			endcase
			send_frame(1'($urandom_range(1)), fluid, total, '1);
		end
	endtask

	// The limit is changed after the fluid count and before the total count of one frame.
	task automatic test_limit_change_mid_frame();
		int unsigned lim;
		int unsigned fluid;
		logic        v2;
		lim   = $urandom_range(20, 1);
		fluid = $urandom_range(lim);
		v2    = 1'($urandom_range(1));
		send_frame(v2, fluid, lim, 4);
		set_particle_limit(CW'(lim));
		send_item(lim, 1'b0);
		repeat (3 * lim + fluid + (v2 ? 10 : 0)) send_item(rand_word(), 1'b0);
	endtask

	task automatic test_clean_end();
		send_item(rand_word(), 1'b1);
	endtask

	task automatic test_truncated();
		int unsigned total;
		int unsigned cut;
		set_particle_limit(31'h7FFF_FFFF);
		if ($urandom_range(1)) begin
			total = $urandom_range(32'h7FFF_FFFF, 32'h7FFF_FF00);
			cut   = $urandom_range(12, 1);
		end else begin
			total = $urandom_range(6);
			cut   = $urandom_range(4, 1);
		end
		send_frame(1'($urandom_range(1)), $urandom_range(total), total, cut);
		send_item(rand_word(), 1'b1);
	endtask

	task automatic test_bad_magic();
		logic [WW-1:0] w;
		if ($urandom_range(1)) begin
			w = ($urandom_range(1) ? sfwp_pkg::MagicV1 : sfwp_pkg::MagicV2) ^
				(32'd1 << $urandom_range(31));
		end else begin
			w = rand_word();
			if (w == sfwp_pkg::MagicV1 || w == sfwp_pkg::MagicV2) begin
				w = ~w;
			end
		end
		send_item(w, 1'b0);
	endtask

	task automatic test_bad_counts();
		logic [WW-1:0] fluid;
		logic [WW-1:0] total;
		case ($urandom_range(3))
			0: begin
				fluid = 32'h8000_0000 | $urandom;
				total = $urandom_range(100);
			end
			1: begin
				fluid = $urandom_range(100);
				total = 32'h8000_0000 | $urandom;
			end
			2: begin
				total = $urandom_range(100);
				fluid = $urandom_range(32'h7FFF_FFFF, total + 1);
			end
			default: begin
				set_particle_limit(31'($urandom_range(1000)));
				total = $urandom_range(32'h7FFF_FFFF, pr_limit + 1);
				fluid = $urandom_range(total);
			end
		endcase
		send_frame(1'($urandom_range(1)), fluid, total, 5);
	endtask

	task automatic test_halted();
		for (int i = 0; i < 8; i++) begin
			send_item(rand_word(), (i == 0) ? 1'b1 : 1'($urandom_range(1)));
		end
	endtask

	initial begin
		src_gap_pct    = 32;
		sink_stall_pct = 46;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_frame();
		test_word_extremes();
		test_zero_limit();
		test_random_frames(32, 46, 31'h7FFF_FFFF, 620);
		test_random_frames(46, 32, 31'($urandom_range(24, 1)), 620);
		test_limit_change_mid_frame();
		test_random_frames(0, 0, 31'($urandom_range(2000000, 200)), 620);
		case ($urandom_range(3))
			0:       test_clean_end();
			1:       test_truncated();
			2:       test_bad_magic();
			default: test_bad_counts();
		endcase
		test_halted();
		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("sim_frame_word_parser_top: match");
		end else begin
			$display("sim_frame_word_parser_top: mismatch");
		end
		$finish;
	end

endmodule
